// ===== sv/uart_tx_ring_queue_core_macros.svh =====
// Assertion helpers shared by the transmit queue modules.
`ifndef UART_TX_RING_QUEUE_CORE_MACROS_SVH
`define UART_TX_RING_QUEUE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UARTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UARTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/uartq_pkg.sv =====
`timescale 1ns / 1ps
package uartq_pkg;

  localparam int UARTQ_DEPTH = 16;
  localparam int DATA_W = 8;
  localparam int OP_W = 2;
  localparam int CNT_W = 8;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_DONE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 8'd100;

  typedef struct packed {
    logic tx_valid;
    logic overflow;
    logic write_status;
    logic queue_empty;
    logic busy_res;
  } res_flags_t;

endpackage

// ===== sv/uartq_cmd_if.sv =====
`timescale 1ns / 1ps
interface uartq_cmd_if;
  import uartq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] data;
  logic              last_byte;

  modport source(output valid, operation, data, last_byte, input ready);
  modport sink(input valid, operation, data, last_byte, output ready);
endinterface

// ===== sv/uartq_res_if.sv =====
`timescale 1ns / 1ps
interface uartq_res_if;
  import uartq_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [DATA_W-1:0] tx_byte;
  logic              overflow;
  logic              write_status;
  logic              queue_empty;
  logic              busy_res;

  modport source(output valid, tx_valid, tx_byte, overflow, write_status, queue_empty,
                 busy_res, input ready);
  modport sink(input valid, tx_valid, tx_byte, overflow, write_status, queue_empty,
               busy_res, output ready);
endinterface

// ===== sv/uartq_mem.sv =====
`timescale 1ns / 1ps
module uartq_mem #(
  parameter int DEPTH = uartq_pkg::UARTQ_DEPTH
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [uartq_pkg::DATA_W-1:0]     wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [uartq_pkg::DATA_W-1:0]     rdata
);
  import uartq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the entry being written in the same cycle returns the new byte.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ===== sv/uartq_ctrl.sv =====
`timescale 1ns / 1ps
`include "uart_tx_ring_queue_core_macros.svh"
module uartq_ctrl #(
  parameter int DEPTH = uartq_pkg::UARTQ_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [uartq_pkg::OP_W-1:0]       operation,
  input  logic [uartq_pkg::DATA_W-1:0]     data,
  input  logic                             last_byte,
  input  logic                             cfg_we,
  input  logic [uartq_pkg::CNT_W-1:0]      cfg_data,
  output logic                             mem_we,
  output logic [$clog2(DEPTH)-1:0]         mem_waddr,
  output logic [uartq_pkg::DATA_W-1:0]     mem_wdata,
  output logic                             mem_re,
  output logic [$clog2(DEPTH)-1:0]         mem_raddr,
  output uartq_pkg::res_flags_t            flags
);
  import uartq_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [PW-1:0]    head, head_next;
  logic [PW-1:0]    tail, tail_next;
  logic             busy, busy_next;
  logic             irq_en, irq_en_next;
  logic [CNT_W-1:0] stall, stall_next;
  logic             call_ovf, call_ovf_next;
  logic [CNT_W-1:0] timeout_limit;

  logic [PW-1:0]    h1;
  logic [PW-1:0]    tn;
  logic [PW-1:0]    hn;
  logic [CNT_W-1:0] stall_inc;
  logic             ovf;
  logic             ovf_seen;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    busy_next     = busy;
    irq_en_next   = irq_en;
    stall_next    = stall;
    call_ovf_next = call_ovf;
    mem_we        = 1'b0;
    mem_waddr     = tail;
    mem_wdata     = data;
    mem_re        = 1'b0;
    mem_raddr     = nxt(head);
    flags         = '0;
    tn            = nxt(tail);
    hn            = nxt(head);
    ovf           = (head == tn);
    h1            = ovf ? hn : head;
    ovf_seen      = call_ovf | ovf;
    stall_inc     = stall + CNT_W'(1);

    case (operation)
      OP_PUSH: begin
        mem_we         = accept;
        tail_next      = tn;
        head_next      = h1;
        flags.overflow = ovf;
        if (!busy) begin
          busy_next      = 1'b1;
          head_next      = nxt(h1);
          irq_en_next    = 1'b1;
          flags.tx_valid = 1'b1;
          mem_re         = accept;
          mem_raddr      = nxt(h1);
        end
        flags.write_status = ovf_seen;
        call_ovf_next      = last_byte ? 1'b0 : ovf_seen;
      end
      OP_DONE: begin
        if (irq_en) begin
          stall_next = '0;
          if (tail == hn) begin
            irq_en_next = 1'b0;
            busy_next   = 1'b0;
          end else begin
            flags.tx_valid = 1'b1;
            mem_re         = accept;
            mem_raddr      = hn;
            head_next      = hn;
          end
        end
      end
      OP_TICK: begin
        if (busy) begin
          if (stall_inc > timeout_limit) begin
            stall_next = '0;
            busy_next  = 1'b0;
          end else begin
            stall_next = stall_inc;
          end
        end
      end
      default: begin
      end
    endcase

    flags.queue_empty = (nxt(head_next) == tail_next);
    flags.busy_res    = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= PW'(1);
      busy     <= 1'b0;
      irq_en   <= 1'b0;
      stall    <= '0;
      call_ovf <= 1'b0;
    end else if (accept) begin
      head     <= head_next;
      tail     <= tail_next;
      busy     <= busy_next;
      irq_en   <= irq_en_next;
      stall    <= stall_next;
      call_ovf <= call_ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_limit <= cfg_data;
    end
  end

  `UARTQ_ASSERT_NOW(a_ptrs_apart, clk, rst, 1'b1, head != tail,
                    "Head and tail pointers coincide.")
  `UARTQ_ASSERT_NEXT(a_push_moves_tail, clk, rst, accept && (operation == OP_PUSH),
                     tail != $past(tail), "A push request did not advance the tail.")
  `UARTQ_ASSERT_NOW(a_busy_irq, clk, rst, busy && !irq_en, 1'b0,
                    "Transmitter is busy with its done interrupt disabled.")

endmodule

// ===== sv/uart_tx_ring_queue_core.sv =====
// An accepted request goes through the read stage to the output stage that presents it.
// Throughput: one request per cycle unless the output stalls; pointers, store write and
// store read all update at the accepting edge; the registered read feeds the output stage.
// Reset (rst, synchronous): pointers return to head 0 and tail 1, the transmitter is idle,
// the timeout limit returns to 100 and both pipeline stages empty; the store is not cleared.
`timescale 1ns / 1ps
`include "uart_tx_ring_queue_core_macros.svh"
module uart_tx_ring_queue_core #(
  parameter int DEPTH = uartq_pkg::UARTQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  uartq_cmd_if.sink                    cmd,
  uartq_res_if.source                  res,
  input  logic                         cfg_we,
  input  logic [uartq_pkg::CNT_W-1:0]  cfg_data
);
  import uartq_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic              accept;
  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  res_flags_t        flags;

  logic              s1_valid;
  res_flags_t        s1_flags;
  logic              s1_advance;

  logic              out_valid;
  res_flags_t        out_flags;
  logic [DATA_W-1:0] out_byte;

  assign s1_advance = s1_valid && (!out_valid || res.ready);
  assign cmd.ready  = !s1_valid || s1_advance;
  assign accept     = cmd.valid && cmd.ready;

  uartq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (cmd.operation),
    .data      (cmd.data),
    .last_byte (cmd.last_byte),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .flags     (flags)
  );

  uartq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_flags <= s1_flags;
      out_byte  <= s1_flags.tx_valid ? mem_rdata : '0;
    end
  end

  assign res.valid        = out_valid;
  assign res.tx_valid     = out_flags.tx_valid;
  assign res.tx_byte      = out_byte;
  assign res.overflow     = out_flags.overflow;
  assign res.write_status = out_flags.write_status;
  assign res.queue_empty  = out_flags.queue_empty;
  assign res.busy_res     = out_flags.busy_res;

  `UARTQ_ASSERT_NEXT(a_accept_fills_s1, clk, rst, accept, s1_valid,
                     "An accepted request did not reach the read stage.")
  `UARTQ_ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !s1_advance,
                     s1_valid && $stable(s1_flags), "A waiting request left the read stage.")
  `UARTQ_ASSERT_NOW(a_idle_byte_zero, clk, rst, out_valid && !out_flags.tx_valid,
                    out_byte == '0, "A result without a byte carries a non-zero byte.")

endmodule
